>>> design/strided_sliding_window_buffer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the strided sliding window buffer
// Short forms for clocked implication checks with synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef STRIDED_SLIDING_WINDOW_BUFFER_MACROS_SVH
`define STRIDED_SLIDING_WINDOW_BUFFER_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on the same edge.
`define SSWB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sswb assertion failed");

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define SSWB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sswb assertion failed");

`endif

>>> design/sswb_pkg.sv
// ----------------------------------------------------------------------------
// sswb_pkg
// Shared constants, payload types and frame packing helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sswb_pkg;

  localparam int WINDOW_LEN  = 64;
  localparam int CHANNELS    = 10;
  localparam int MAX_CHAN    = 10;
  localparam int SAMPLE_W    = 24;
  localparam int HOP_W       = 7;
  localparam int PTR_W       = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [HOP_W-1:0] HOP_RESET = HOP_W'(16);

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] frame_t;
  typedef logic [MAX_CHAN-1:0][SAMPLE_W-1:0] frame_pad_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] chan0_in;
    logic signed [SAMPLE_W-1:0] chan1_in;
    logic signed [SAMPLE_W-1:0] chan2_in;
    logic signed [SAMPLE_W-1:0] chan3_in;
    logic signed [SAMPLE_W-1:0] chan4_in;
    logic signed [SAMPLE_W-1:0] chan5_in;
    logic signed [SAMPLE_W-1:0] chan6_in;
    logic signed [SAMPLE_W-1:0] chan7_in;
    logic signed [SAMPLE_W-1:0] chan8_in;
    logic signed [SAMPLE_W-1:0] chan9_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] chan0_out;
    logic signed [SAMPLE_W-1:0] chan1_out;
    logic signed [SAMPLE_W-1:0] chan2_out;
    logic signed [SAMPLE_W-1:0] chan3_out;
    logic signed [SAMPLE_W-1:0] chan4_out;
    logic signed [SAMPLE_W-1:0] chan5_out;
    logic signed [SAMPLE_W-1:0] chan6_out;
    logic signed [SAMPLE_W-1:0] chan7_out;
    logic signed [SAMPLE_W-1:0] chan8_out;
    logic signed [SAMPLE_W-1:0] chan9_out;
    logic                       window_last;
  } out_item_t;

  // Status of the window reader, seen by the front for overwrite protection.
  typedef struct packed {
    logic busy;
    ptr_t base;
    ptr_t rd_cnt;
  } back_status_t;

  // Channels above CHANNELS are dropped on the way in.
  function automatic frame_t in_to_frame(in_item_t it);
    frame_pad_t pad;
    pad[0] = it.chan0_in;
    pad[1] = it.chan1_in;
    pad[2] = it.chan2_in;
    pad[3] = it.chan3_in;
    pad[4] = it.chan4_in;
    pad[5] = it.chan5_in;
    pad[6] = it.chan6_in;
    pad[7] = it.chan7_in;
    pad[8] = it.chan8_in;
    pad[9] = it.chan9_in;
    return pad[CHANNELS-1:0];
  endfunction

  // Channels above CHANNELS read as zero on the way out.
  function automatic out_item_t frame_to_out(frame_t f, logic last);
    frame_pad_t pad;
    out_item_t  o;
    pad = '0;
    pad[CHANNELS-1:0] = f;
    o.chan0_out   = pad[0];
    o.chan1_out   = pad[1];
    o.chan2_out   = pad[2];
    o.chan3_out   = pad[3];
    o.chan4_out   = pad[4];
    o.chan5_out   = pad[5];
    o.chan6_out   = pad[6];
    o.chan7_out   = pad[7];
    o.chan8_out   = pad[8];
    o.chan9_out   = pad[9];
    o.window_last = last;
    return o;
  endfunction

endpackage

`default_nettype wire

>>> design/sswb_hist.sv
// ----------------------------------------------------------------------------
// sswb_hist
// Frame history memory with one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sswb_hist (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_en,
  input  wire sswb_pkg::ptr_t   wr_addr,
  input  wire sswb_pkg::frame_t wr_data,
  input  wire logic            rd_en,
  input  wire sswb_pkg::ptr_t   rd_addr,
  output sswb_pkg::frame_t      rd_frame
);

  sswb_pkg::frame_t mem [sswb_pkg::WINDOW_LEN];

  // One valid bit per slot stands in for the all-zero reset of the history.
  logic [sswb_pkg::WINDOW_LEN-1:0] vld_r;
  sswb_pkg::frame_t                rd_data_r;
  logic                            rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_frame = rd_vld_r ? rd_data_r : '0;

endmodule

`default_nettype wire

>>> design/sswb_cmdq.sv
// ----------------------------------------------------------------------------
// sswb_cmdq
// Short queue of window start pointers between the front and the reader.
// ----------------------------------------------------------------------------
`default_nettype none

module sswb_cmdq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire sswb_pkg::ptr_t push_base,
  input  wire logic          pop,
  output sswb_pkg::ptr_t      pop_base,
  output logic               empty,
  output logic               full
);

  // Entry registers; with two entries this is a register bank, not a memory.
  sswb_pkg::ptr_t [sswb_pkg::QUEUE_DEPTH-1:0] q_data_r;

  logic [sswb_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [sswb_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [sswb_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                        do_push, do_pop;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == sswb_pkg::QCNT_W'(sswb_pkg::QUEUE_DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_base = q_data_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == sswb_pkg::QPTR_W'(sswb_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == sswb_pkg::QPTR_W'(sswb_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_data_r[wr_ptr_r] <= push_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/sswb_front.sv
// ----------------------------------------------------------------------------
// sswb_front
// Accepts frames, writes the history, counts the hop and queues windows.
// ----------------------------------------------------------------------------
`default_nettype none

module sswb_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire sswb_pkg::in_item_t             in_item,
  input  wire logic                          cfg_we,
  input  wire logic [sswb_pkg::HOP_W-1:0]    cfg_wdata,
  input  wire sswb_pkg::back_status_t         back_st,
  input  wire logic                          q_empty,
  output logic                               q_push,
  output sswb_pkg::ptr_t                      q_base,
  output logic                               wr_en,
  output sswb_pkg::ptr_t                      wr_addr,
  output sswb_pkg::frame_t                    wr_data
);

  sswb_pkg::ptr_t             wp_r, wp_nxt, wp_inc;
  logic [sswb_pkg::HOP_W-1:0] hop_cnt_r, hop_cnt_nxt, hop_inc;
  logic [sswb_pkg::HOP_W-1:0] hop_len_r;
  logic [sswb_pkg::PTR_W:0]   wrap_sum;
  sswb_pkg::ptr_t             offset;
  logic                       safe, acc, emit;

  // Distance of the write slot from the start of the window being read.
  assign wrap_sum = {1'b0, wp_r} + (sswb_pkg::PTR_W + 1)'(sswb_pkg::WINDOW_LEN)
                    - {1'b0, back_st.base};
  assign offset   = (wp_r >= back_st.base) ? wp_r - back_st.base
                                           : wrap_sum[sswb_pkg::PTR_W-1:0];

  // A slot may be overwritten only once the reader has fetched it.
  assign safe     = !back_st.busy || (back_st.rd_cnt > offset);
  assign in_stall = !(q_empty && safe);
  assign acc      = in_valid && !in_stall;

  assign wp_inc  = (wp_r == sswb_pkg::PTR_W'(sswb_pkg::WINDOW_LEN - 1)) ? '0 : wp_r + 1'b1;
  assign hop_inc = hop_cnt_r + 1'b1;
  assign emit    = (hop_inc >= hop_len_r);

  assign wr_en   = acc;
  assign wr_addr = wp_r;
  assign wr_data = sswb_pkg::in_to_frame(in_item);
  assign q_push  = acc && emit;
  assign q_base  = wp_inc;

  always_comb begin
    wp_nxt      = wp_r;
    hop_cnt_nxt = hop_cnt_r;
    if (acc) begin
      wp_nxt      = wp_inc;
      hop_cnt_nxt = emit ? '0 : hop_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      hop_cnt_r <= '0;
      hop_len_r <= sswb_pkg::HOP_RESET;
    end else begin
      wp_r      <= wp_nxt;
      hop_cnt_r <= hop_cnt_nxt;
      if (cfg_we) begin
        hop_len_r <= cfg_wdata;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/sswb_back.sv
// ----------------------------------------------------------------------------
// sswb_back
// Window reader: walks the history oldest-first and feeds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sswb_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  output logic               q_pop,
  input  wire sswb_pkg::ptr_t q_base,
  input  wire logic          out_stall,
  output logic               out_valid,
  output logic               out_last,
  output sswb_pkg::back_status_t st,
  output logic               rd_en,
  output sswb_pkg::ptr_t      rd_addr
);

  logic           busy_r, busy_nxt;
  sswb_pkg::ptr_t base_r, base_nxt;
  sswb_pkg::ptr_t addr_r, addr_nxt;
  sswb_pkg::ptr_t cnt_r, cnt_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           last_r, last_nxt;
  logic           issue, at_end;

  // A read is issued only when the output register is free or being emptied.
  assign issue  = busy_r && (!out_valid_r || !out_stall);
  assign at_end = (cnt_r == sswb_pkg::PTR_W'(sswb_pkg::WINDOW_LEN - 1));
  assign q_pop  = !busy_r && !q_empty;

  always_comb begin
    busy_nxt      = busy_r;
    base_nxt      = base_r;
    addr_nxt      = addr_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (q_pop) begin
      busy_nxt = 1'b1;
      base_nxt = q_base;
      addr_nxt = q_base;
      cnt_nxt  = '0;
    end
    if (issue) begin
      out_valid_nxt = 1'b1;
      last_nxt      = at_end;
      addr_nxt      = (addr_r == sswb_pkg::PTR_W'(sswb_pkg::WINDOW_LEN - 1)) ? '0
                                                                             : addr_r + 1'b1;
      if (at_end) begin
        busy_nxt = 1'b0;
        cnt_nxt  = '0;
      end else begin
        cnt_nxt  = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    addr_r <= addr_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_last  = last_r;
  assign rd_en     = issue;
  assign rd_addr   = addr_r;
  assign st.busy   = busy_r;
  assign st.base   = base_r;
  assign st.rd_cnt = cnt_r;

endmodule

`default_nettype wire

>>> design/strided_sliding_window_buffer.sv
// The window start of a completed hop passes the queue entry, then the reader's address
// register, then the read data register that shows the first frame. Throughput: one result
// per cycle while a window drains and the output is not stalled; input items are taken one per
// cycle while no window is pending; during a drain each frame follows the reader by one slot.
// Reset: synchronous, active low; the history reads as all zero frames.
// ----------------------------------------------------------------------------
// strided_sliding_window_buffer
// Circular frame history that emits the whole window, oldest first, every hop.
// ----------------------------------------------------------------------------
`default_nettype none
`include "strided_sliding_window_buffer_macros.svh"

module strided_sliding_window_buffer (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire sswb_pkg::in_item_t          in_item,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output sswb_pkg::out_item_t              out_item,
  input  wire logic                       cfg_we,
  input  wire logic [sswb_pkg::HOP_W-1:0] cfg_wdata
);

  // The front writes each accepted item into the history at the write pointer and
  // counts the hop. When the hop completes it queues the start pointer of the
  // window, which is the slot after the newest frame and so the oldest one.
  // The back pops that pointer and reads the 64 slots in order through a
  // registered memory port; the read data register is the output register.
  // The front holds off new items while a window waits in the queue, and while a
  // window drains it only writes slots the reader has already fetched.

  sswb_pkg::back_status_t back_st;
  logic                   q_push, q_pop, q_empty, q_full;
  sswb_pkg::ptr_t         q_push_base, q_pop_base;
  logic                   hist_wr_en;
  sswb_pkg::ptr_t         hist_wr_addr;
  sswb_pkg::frame_t       hist_wr_data;
  logic                   rd_en;
  sswb_pkg::ptr_t         rd_addr;
  sswb_pkg::frame_t       rd_frame;
  logic                   out_last;
  logic                   rd_final;

  sswb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .back_st   (back_st),
    .q_empty   (q_empty),
    .q_push    (q_push),
    .q_base    (q_push_base),
    .wr_en     (hist_wr_en),
    .wr_addr   (hist_wr_addr),
    .wr_data   (hist_wr_data)
  );

  sswb_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_base (q_push_base),
    .pop       (q_pop),
    .pop_base  (q_pop_base),
    .empty     (q_empty),
    .full      (q_full)
  );

  sswb_hist u_hist (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (hist_wr_en),
    .wr_addr  (hist_wr_addr),
    .wr_data  (hist_wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_frame (rd_frame)
  );

  sswb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_base    (q_pop_base),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_last  (out_last),
    .st        (back_st),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr)
  );

  // Unused channels are zeroed here, and the last flag rides with the data.
  assign out_item = sswb_pkg::frame_to_out(rd_frame, out_last);

  // The read of the newest slot of a window.
  assign rd_final = rd_en && (back_st.rd_cnt == sswb_pkg::PTR_W'(sswb_pkg::WINDOW_LEN - 1));

  // A window is only queued when nothing else is waiting.
  `SSWB_ASSERT_IMPL(a_q_no_overflow, clk, rst_n, q_push, !q_full)
  // The front never overwrites the slot the reader is fetching.
  `SSWB_ASSERT_IMPL(a_no_rw_clash, clk, rst_n, hist_wr_en && rd_en, hist_wr_addr != rd_addr)
  // Every window starts reading at its oldest slot.
  `SSWB_ASSERT_IMPL(a_start_oldest, clk, rst_n, $rose(back_st.busy), back_st.rd_cnt == '0)
  // The final read of a window ends the drain.
  `SSWB_ASSERT_NEXT(a_last_ends, clk, rst_n, rd_final, !back_st.busy && out_item.window_last)

endmodule

`default_nettype wire

>>> bench/tb_strided_sliding_window_buffer.sv
// ----------------------------------------------------------------------------
// Testbench for the strided sliding window buffer
// Drives sample frames and hop length settings into the block and holds its
// own copy of the frame history and hop counter. Every window frame that comes
// out is compared field by field with the frame that the copy says is due.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_strided_sliding_window_buffer;
  import sswb_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 5;
  localparam int MAX_IDLE     = 12;
  localparam int RANDOM_ITEMS = 325;
  localparam int SETTLE       = 4;
  // The slowest correct run is about 350 items times one full window each under
  // the longest receiver stall. The limit leaves plenty of room above that.
  localparam int CYCLE_LIMIT  = 1500000;

  // How a row of the directed table is checked. Rows that can cause no window
  // have their (empty) answer written in; every other row goes to the model.
  typedef enum logic {
    CHECK_BY_MODEL,
    CHECK_QUIET
  } row_check_t;

  typedef struct {
    logic                set_hop;
    logic [HOP_W-1:0]    hop;
    logic [SAMPLE_W-1:0] fill;
    logic                spread;
    int unsigned         copies;
    row_check_t          check;
  } plan_row_t;

  typedef logic [MAX_CHAN-1:0][SAMPLE_W-1:0] lanes_t;

  localparam int PLAN_ROWS = 9;

  // Directed opening. With spread set, each copy of a row carries distinct
  // samples, so the oldest-first order of the window is visible.
  plan_row_t plan [PLAN_ROWS] = '{
    // Reset hop length of 16: fifteen frames cause nothing.
    '{1'b0, 7'd0,   24'h123456, 1'b1, 15, CHECK_QUIET},
    // The sixteenth frame emits 48 zero frames from reset, then the 16 new ones.
    '{1'b0, 7'd0,   24'h7FFFFF, 1'b0, 1,  CHECK_BY_MODEL},
    // Hop length one: every frame emits, with the sample extremes.
    '{1'b1, 7'd1,   24'h800000, 1'b0, 1,  CHECK_BY_MODEL},
    '{1'b0, 7'd0,   24'h000000, 1'b0, 1,  CHECK_BY_MODEL},
    '{1'b0, 7'd0,   24'hFFFFFF, 1'b0, 1,  CHECK_BY_MODEL},
    // Hop length zero behaves like one.
    '{1'b1, 7'd0,   24'h555555, 1'b0, 1,  CHECK_BY_MODEL},
    '{1'b0, 7'd0,   24'hAAAAAA, 1'b0, 1,  CHECK_BY_MODEL},
    // Count three frames against a hop of five ...
    '{1'b1, 7'd5,   24'h0F0F0F, 1'b1, 3,  CHECK_QUIET},
    // ... then lower the hop below the count: the next frame emits at once.
    '{1'b1, 7'd2,   24'hF0F0F0, 1'b1, 1,  CHECK_BY_MODEL}
  };

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_item_t            in_item   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_item;
  logic                cfg_we    = 1'b0;
  logic [HOP_W-1:0]    cfg_wdata = '0;

  // Model of the block: frame history, write slot, hop counter and setting.
  logic [SAMPLE_W-1:0] hist_mem [WINDOW_LEN][MAX_CHAN];
  int unsigned         next_slot;
  logic [HOP_W-1:0]    frames_since_window;
  logic [HOP_W-1:0]    hop_len;

  out_item_t           window_due [$];
  int unsigned         mismatches  = 0;
  int unsigned         cycle_count = 0;
  int unsigned         stall_left  = 0;
  bit                  tx_burst    = 1'b0;
  bit                  rx_burst    = 1'b0;

  strided_sliding_window_buffer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watchdog: a hung handshake or a missing window frame ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_strided_sliding_window_buffer failed");
      $finish;
    end
  end

  // Writes one frame into the model history and, when the hop is complete,
  // appends the whole window, oldest first, to the given queue. Channel fields
  // at or above CHANNELS are stored as zero. Returns the number of frames added.
  function automatic int unsigned advance_window(input in_item_t it, ref out_item_t win[$]);
    lanes_t      lanes_in;
    lanes_t      lanes_out;
    int unsigned src;
    lanes_in = it;
    for (int c = 0; c < MAX_CHAN; c++) begin
      hist_mem[next_slot][c] = (c < CHANNELS) ? lanes_in[MAX_CHAN-1-c] : '0;
    end
    next_slot = (next_slot + 1) % WINDOW_LEN;
    frames_since_window = frames_since_window + 1'b1;
    // Greater-or-equal, so a hop of zero fires every frame and a hop lowered
    // below the running count fires on the very next frame.
    if (frames_since_window < hop_len) begin
      return 0;
    end
    frames_since_window = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      src = (next_slot + i) % WINDOW_LEN;
      for (int c = 0; c < MAX_CHAN; c++) begin
        lanes_out[MAX_CHAN-1-c] = (c < CHANNELS) ? hist_mem[src][c] : '0;
      end
      win.push_back(out_item_t'({lanes_out, (i == WINDOW_LEN - 1) ? 1'b1 : 1'b0}));
    end
    return WINDOW_LEN;
  endfunction

  // Compares one accepted window frame with the oldest frame due.
  task automatic check_frame(input out_item_t got);
    out_item_t want;
    lanes_t    lanes_got;
    lanes_t    lanes_want;
    logic      last_got;
    logic      last_want;
    if (window_due.size() == 0) begin
      $error("window frame arrived with none due: window_last=%0b", got.window_last);
      mismatches++;
      return;
    end
    want = window_due.pop_front();
    {lanes_got, last_got}   = got;
    {lanes_want, last_want} = want;
    for (int c = 0; c < MAX_CHAN; c++) begin
      if (lanes_got[MAX_CHAN-1-c] !== lanes_want[MAX_CHAN-1-c]) begin
        $error("chan%0d_out: expected %0d, got %0d", c,
               $signed(lanes_want[MAX_CHAN-1-c]), $signed(lanes_got[MAX_CHAN-1-c]));
        mismatches++;
      end
    end
    if (last_got !== last_want) begin
      $error("window_last: expected %0b, got %0b", last_want, last_got);
      mismatches++;
    end
  endtask

  // Result side. Every accepted item is checked, then a fresh stall length is
  // drawn. Stalls also run while nothing is valid, so they land on every phase
  // of a window drain.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_frame(out_item);
        stall_left = rx_burst ? 0 : $urandom_range(0, MAX_IDLE);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // Presents one frame after a random gap and holds it until accepted. The
  // expected window frames go on the queue at the accepting edge, well before
  // the first of them can appear.
  task automatic send_frame(input in_item_t it, input row_check_t check);
    int unsigned gap;
    out_item_t   fresh [$];
    gap = tx_burst ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    void'(advance_window(it, fresh));
    // Quiet rows expect nothing by construction; the model still advances.
    if (check == CHECK_BY_MODEL) begin
      foreach (fresh[k]) window_due.push_back(fresh[k]);
    end
  endtask

  // Stops sending and waits until every window frame due has come, then waits
  // out the settle time for a frame that is still in flight but emits nothing.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (window_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // The hop register is only written while the block is idle.
  task automatic write_hop(input logic [HOP_W-1:0] hop);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= hop;
    @(posedge clk);
    cfg_we    <= 1'b0;
    hop_len = hop;
  endtask

  initial begin
    in_item_t    frame;
    lanes_t      lanes;
    int unsigned sent;
    int unsigned phase_len;
    int unsigned pick;
    int unsigned phase;
    logic [HOP_W-1:0] hop;

    for (int s = 0; s < WINDOW_LEN; s++) begin
      for (int c = 0; c < MAX_CHAN; c++) begin
        hist_mem[s][c] = '0;
      end
    end
    next_slot           = 0;
    frames_since_window = '0;
    hop_len             = HOP_RESET;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    foreach (plan[r]) begin
      if (plan[r].set_hop) begin
        write_hop(plan[r].hop);
      end
      for (int unsigned k = 0; k < plan[r].copies; k++) begin
        for (int c = 0; c < MAX_CHAN; c++) begin
          lanes[MAX_CHAN-1-c] = plan[r].spread ? (plan[r].fill ^ {k[11:0], c[11:0]})
                                               : plan[r].fill;
        end
        frame = lanes;
        send_frame(frame, plan[r].check);
      end
    end

    // Random phases. Each phase sets a new hop length while the block is idle
    // and leaves the hop counter running, so a hop often lands below the
    // count already reached. The first phases take the long hops: the largest
    // encodable value and the full window.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (phase == 0) begin
        hop = '1;
      end else if (phase == 1) begin
        hop = HOP_W'(WINDOW_LEN);
      end else if (pick == 0) begin
        hop = '0;
      end else if (pick == 1) begin
        hop = '1;
      end else if (pick == 2) begin
        hop = HOP_W'($urandom_range(WINDOW_LEN + 1, 126));
      end else if (pick == 3) begin
        hop = HOP_W'(WINDOW_LEN);
      end else if (pick < 10) begin
        hop = HOP_W'($urandom_range(1, 4));
      end else begin
        hop = HOP_W'($urandom_range(5, WINDOW_LEN - 1));
      end
      write_hop(hop);

      // Some phases run back to back on one side or both.
      tx_burst  = ($urandom_range(0, 3) == 0);
      rx_burst  = ($urandom_range(0, 3) == 0);
      phase_len = (hop > HOP_W'(WINDOW_LEN) || phase < 2) ? $urandom_range(40, 140)
                                                          : $urandom_range(8, 40);
      for (int unsigned n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
        for (int c = 0; c < MAX_CHAN; c++) begin
          pick = $urandom_range(0, 7);
          case (pick)
            0: lanes[MAX_CHAN-1-c] = 24'h800000;
            1: lanes[MAX_CHAN-1-c] = 24'h7FFFFF;
            2: lanes[MAX_CHAN-1-c] = 24'h000000;
            3: lanes[MAX_CHAN-1-c] = 24'hFFFFFF;
            default: lanes[MAX_CHAN-1-c] = SAMPLE_W'($urandom);
          endcase
        end
        frame = lanes;
        send_frame(frame, CHECK_BY_MODEL);
        sent++;
      end
      phase++;
    end

    // Drain the last window and give any stray frame time to show up.
    tx_burst = 1'b0;
    wait_drained();
    repeat (2 * SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_strided_sliding_window_buffer passed");
    end else begin
      $display("tb_strided_sliding_window_buffer failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
